// ===== rtl/core/pwfd_pkg.sv =====
// Shared types, codes and constants for the pulse-width frame decoder.
// Used by the front end, the command queue, the back end and the top level.
// Depends on nothing.
package pwfd_pkg;

  localparam int unsigned DefFrameBytes = 32;
  localparam logic [7:0]  CrcPoly       = 8'h8C;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GLITCH_MAX = 3'd0,
    REG_SHORT_MAX  = 3'd1,
    REG_LONG_MAX   = 3'd2,
    REG_SYNC_MAX   = 3'd3,
    REG_FRAME_GAP  = 3'd4
  } reg_idx_t;

  localparam logic [15:0] RstGlitchMax = 16'd100;
  localparam logic [15:0] RstShortMax  = 16'd400;
  localparam logic [15:0] RstLongMax   = 16'd900;
  localparam logic [15:0] RstSyncMax   = 16'd2000;
  localparam logic [15:0] RstFrameGap  = 16'd1500;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_EVENT   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CRC_UNCHECKED = 2'd0,
    CRC_MATCH     = 2'd1,
    CRC_MISMATCH  = 2'd2
  } crc_status_t;

  typedef enum logic [1:0] {
    OP_BIT0        = 2'd0,
    OP_BIT1        = 2'd1,
    OP_FLUSH       = 2'd2,
    OP_FLUSH_EVENT = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] duration;
  } cmd_t;

  // Command queue status: valid goes to the back end, full to the front end.
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 96;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = data;
    for (int i = 0; i < 8; i++) begin
      if ((c[0] ^ d[0]) == 1'b1) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/pwfd_front.sv =====
// Front end: holds the threshold registers and classes each accepted edge
// into a command for the back end. Depends on pwfd_pkg.
module pwfd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pwfd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pwfd_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  input  logic                          in_mode,
  input  logic                          in_level,
  input  logic [31:0]                   in_duration,
  input  logic                          q_full,
  output logic                          in_ready,
  output logic                          push,
  output pwfd_pkg::cmd_t                push_cmd
);
  import pwfd_pkg::*;

  logic [15:0] glitch_max;
  logic [15:0] short_max;
  logic [15:0] long_max;
  logic [15:0] sync_max;
  logic [15:0] frame_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      glitch_max <= RstGlitchMax;
      short_max  <= RstShortMax;
      long_max   <= RstLongMax;
      sync_max   <= RstSyncMax;
      frame_gap  <= RstFrameGap;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_GLITCH_MAX: glitch_max <= cfg_data;
        REG_SHORT_MAX:  short_max  <= cfg_data;
        REG_LONG_MAX:   long_max   <= cfg_data;
        REG_SYNC_MAX:   sync_max   <= cfg_data;
        REG_FRAME_GAP:  frame_gap  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic gap_over;
  logic has_cmd;
  op_t  op;

  assign gap_over = in_duration > {16'd0, frame_gap};
  assign in_ready = !q_full;

  // Thresholds are tried in a fixed order; the first that matches wins.
  always_comb begin
    has_cmd = 1'b0;
    op      = OP_FLUSH;
    if (in_mode || !in_level) begin
      has_cmd = gap_over;
    end else if (in_duration < {16'd0, glitch_max}) begin
      has_cmd = 1'b0;
    end else if (in_duration < {16'd0, short_max}) begin
      has_cmd = 1'b1;
      op      = OP_BIT1;
    end else if (in_duration < {16'd0, long_max}) begin
      has_cmd = 1'b1;
      op      = OP_BIT0;
    end else if (in_duration < {16'd0, sync_max}) begin
      has_cmd = 1'b1;
    end else begin
      has_cmd = 1'b1;
      op      = OP_FLUSH_EVENT;
    end
  end

  assign push              = in_valid && in_ready && has_cmd;
  assign push_cmd.op       = op;
  assign push_cmd.duration = in_duration;

endmodule

// ===== rtl/core/pwfd_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on pwfd_pkg for the command type.
module pwfd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pwfd_pkg::cmd_t       push_cmd,
  input  logic                 pop,
  output pwfd_pkg::q_status_t  status,
  output pwfd_pkg::cmd_t       head
);
  import pwfd_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  cmd_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.valid = fill != '0;
  assign status.full  = fill == (PtrW+1)'(Depth);

endmodule

// ===== rtl/core/pwfd_back.sv =====
// Back end: bit store, frame flush with framing-bit removal and CRC check,
// and the output register. Depends on pwfd_pkg.
module pwfd_back #(
  parameter int unsigned FRAME_BYTES = pwfd_pkg::DefFrameBytes
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pwfd_pkg::q_status_t             q_status,
  input  pwfd_pkg::cmd_t                  q_head,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_kind,
  output logic [pwfd_pkg::OutDataW-1:0]   out_data,
  output logic                            out_last
);
  import pwfd_pkg::*;

  localparam int unsigned IdxW  = $clog2(FRAME_BYTES);
  localparam int unsigned NbW   = $clog2(FRAME_BYTES + 1);
  localparam int unsigned Bits  = FRAME_BYTES * 8;
  localparam int unsigned CntW  = $clog2(Bits + 1);

  typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_USE, ST_SUM, ST_EVENT} state_t;

  state_t          state;
  logic [CntW-1:0] bit_count;
  logic [31:0]     frame_count;
  logic [7:0]      crc_accumulator;
  logic [7:0]      cur_byte;
  logic [7:0]      prev_byte;
  logic [IdxW-1:0] rd_ptr;
  logic [7:0]      rd_data;
  logic [7:0]      bit_store [FRAME_BYTES];

  logic [CntW-1:0] total;
  logic            drop;
  logic [NbW-1:0]  nbytes;
  logic [2:0]      left;
  logic            pend_event;
  logic [31:0]     event_dur;
  crc_status_t     crc_status;
  logic [7:0]      crc_expected;

  logic [7:0]      byte_value;
  logic [7:0]      crc_out;
  crc_status_t     out_status;
  logic [8:0]      total_bits;
  logic            framing_dropped;
  logic [2:0]      tail_bits;
  logic [31:0]     frame_index;
  logic [31:0]     event_duration;

  logic            out_free;
  logic            emit;
  logic            add_bit;
  logic            wr_en;
  logic [7:0]      wr_byte;
  logic            drop_n;
  logic [CntW-1:0] cnt_adj;
  logic [NbW-1:0]  nbytes_n;
  logic [IdxW-1:0] byte_idx;
  logic [7:0]      emit_byte;
  logic            is_last_byte;
  logic            check_crc;

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == ST_IDLE) && q_status.valid;
  assign add_bit  = pop && (q_head.op == OP_BIT0 || q_head.op == OP_BIT1);
  assign wr_en    = add_bit && (bit_count < CntW'(Bits));

  // High in the cycles where a result is loaded into the output register.
  assign emit = out_free && ((state == ST_USE && !(drop && rd_ptr == '0)) ||
                             state == ST_SUM || state == ST_EVENT);

  always_comb begin
    if (bit_count[2:0] == 3'd0) begin
      wr_byte = {7'd0, q_head.op == OP_BIT1};
    end else begin
      wr_byte = cur_byte | (8'(q_head.op == OP_BIT1) << bit_count[2:0]);
    end
  end

  // An 8N+1-bit frame loses its leading bit; the bytes are then realigned on the fly.
  assign drop_n    = bit_count[2:0] == 3'd1;
  assign cnt_adj   = bit_count - (drop_n ? 1'b1 : 1'b0);
  assign nbytes_n  = NbW'(cnt_adj >> 3);
  assign byte_idx  = drop ? rd_ptr - 1'b1 : rd_ptr;
  assign emit_byte = drop ? {rd_data[0], prev_byte[7:1]} : rd_data;
  assign is_last_byte = NbW'(byte_idx) == nbytes - 1'b1;
  assign check_crc = (nbytes >= NbW'(2)) && (left == 3'd0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bit_store[bit_count[IdxW+2:3]] <= wr_byte;
    end
    rd_data <= bit_store[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      bit_count       <= '0;
      frame_count     <= '0;
      crc_accumulator <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            if (add_bit) begin
              if (wr_en) begin
                cur_byte  <= wr_byte;
                bit_count <= bit_count + 1'b1;
              end
            end else if (bit_count != '0) begin
              frame_count     <= frame_count + 1'b1;
              total           <= bit_count;
              drop            <= drop_n;
              nbytes          <= nbytes_n;
              left            <= cnt_adj[2:0];
              pend_event      <= q_head.op == OP_FLUSH_EVENT;
              event_dur       <= q_head.duration;
              crc_status      <= CRC_UNCHECKED;
              crc_expected    <= '0;
              crc_accumulator <= '0;
              rd_ptr          <= '0;
              bit_count       <= '0;
              state           <= (nbytes_n == '0) ? ST_SUM : ST_FETCH;
            end else if (q_head.op == OP_FLUSH_EVENT) begin
              event_dur <= q_head.duration;
              state     <= ST_EVENT;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_USE;
        end
        ST_USE: begin
          if (drop && rd_ptr == '0) begin
            prev_byte <= rd_data;
            rd_ptr    <= rd_ptr + 1'b1;
            state     <= ST_FETCH;
          end else if (out_free) begin
            out_valid       <= 1'b1;
            out_kind        <= KIND_BYTE;
            out_last        <= 1'b0;
            byte_value      <= emit_byte;
            total_bits      <= '0;
            framing_dropped <= 1'b0;
            tail_bits       <= '0;
            crc_out         <= '0;
            out_status      <= CRC_UNCHECKED;
            frame_index     <= frame_count;
            event_duration  <= '0;
            if (is_last_byte) begin
              if (check_crc) begin
                crc_expected <= crc_accumulator;
                crc_status   <= (crc_accumulator == emit_byte) ? CRC_MATCH : CRC_MISMATCH;
              end
              state <= ST_SUM;
            end else begin
              crc_accumulator <= crc8_byte(crc_accumulator, emit_byte);
              prev_byte       <= rd_data;
              rd_ptr          <= rd_ptr + 1'b1;
              state           <= ST_FETCH;
            end
          end
        end
        ST_SUM: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            out_kind        <= KIND_SUMMARY;
            out_last        <= !pend_event;
            byte_value      <= '0;
            total_bits      <= 9'(total);
            framing_dropped <= drop;
            tail_bits       <= left;
            crc_out         <= crc_expected;
            out_status      <= crc_status;
            frame_index     <= frame_count;
            event_duration  <= '0;
            state           <= pend_event ? ST_EVENT : ST_IDLE;
          end
        end
        ST_EVENT: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            out_kind        <= KIND_EVENT;
            out_last        <= 1'b1;
            byte_value      <= '0;
            total_bits      <= '0;
            framing_dropped <= 1'b0;
            tail_bits       <= '0;
            crc_out         <= '0;
            out_status      <= CRC_UNCHECKED;
            frame_index     <= frame_count;
            event_duration  <= event_dur;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_data = {1'b0, event_duration, frame_index, crc_out, out_status,
                     tail_bits, framing_dropped, total_bits, byte_value};

endmodule

// ===== rtl/core/pulse_width_frame_decoder_core.sv =====
// Top level of the pulse-width frame decoder: front end, command queue and
// back end. Depends on pwfd_pkg, pwfd_front, pwfd_queue and pwfd_back.
//
// Input stream: each transfer is a line edge (tuser 0) or an idle check
// (tuser 1), with the new level and the microseconds since the last edge.
// The front end classes each transfer in the cycle it arrives and queues a
// command; transfers that change nothing produce no command. A four-entry
// queue decouples it from the back end, so input is taken every cycle
// until the queue fills.
// The back end stores a bit command without leaving its idle state, so it
// can take the next command at once. A frame flush reads the byte store
// over one port, fetching and then using each emitted byte (with one more
// fetch and use when the framing bit is dropped), then loads the summary
// and, after a long-low event, the event result.
// Results leave through a single output register; while the receiver
// holds tready low the back end waits, the queue fills and tready on the
// input side falls. tlast marks the final result of one input transfer.
// Reset (rst, synchronous) empties the queue, clears the bit and frame
// counts and restores the threshold registers; the store needs no clearing.
// Configuration writes are taken on any cycle that cfg_we is high.
module pulse_width_frame_decoder_core #(
  parameter int unsigned FRAME_BYTES = pwfd_pkg::DefFrameBytes
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pwfd_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [pwfd_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // level [0], duration_us [32:1], zero [39:33]
  input  logic [pwfd_pkg::InDataW-1:0]    s_axis_tdata,
  // mode [0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // byte_value [7:0], total_bits [16:8], framing_bit_dropped [17],
  // tail_bits [20:18], crc_status [22:21], crc_expected [30:23],
  // frame_index [62:31], event_duration_us [94:63], zero [95]
  output logic [pwfd_pkg::OutDataW-1:0]   m_axis_tdata,
  // kind [1:0]
  output logic [1:0]                      m_axis_tuser,
  output logic                            m_axis_tlast
);
  import pwfd_pkg::*;

  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  q_status_t q_status;
  cmd_t      q_head;

  pwfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_axis_tvalid),
    .in_mode     (s_axis_tuser),
    .in_level    (s_axis_tdata[0]),
    .in_duration (s_axis_tdata[32:1]),
    .q_full      (q_status.full),
    .in_ready    (s_axis_tready),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  pwfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .status   (q_status),
    .head     (q_head)
  );

  pwfd_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full) else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_status.valid) else $error("command queue underflow");

  a_byte_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_BYTE) |-> !m_axis_tlast)
    else $error("data byte marked as final result");

endmodule

// ===== dv/pulse_width_frame_decoder_core_tb.sv =====
// Self-checking testbench for pulse_width_frame_decoder_core: directed table
// followed by random pulse trains, checked against an in-bench decoder model.
// Depends on pwfd_pkg and the core RTL.
module pulse_width_frame_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pwfd_pkg::*;

  localparam int unsigned NBytes = 32;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned RandItems = 80;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_value;
    logic [8:0]  total_bits;
    logic        dropped;
    logic [2:0]  leftover;
    crc_status_t crc_status;
    logic [7:0]  crc_expected;
    logic [31:0] frame_index;
    logic [31:0] event_dur;
    logic        last;
  } dec_result_t;

  typedef struct {
    logic        mode;
    logic        level;
    logic [31:0] dur;
    logic        has_exp;
    kind_t       exp_kind;
    logic [31:0] exp_dur;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pulse_width_frame_decoder_core i_dut (.*);

  // Model state and thresholds.
  logic [15:0] thr [5];
  logic [7:0]  store [NBytes];
  int unsigned nbits;
  logic [31:0] frames;
  dec_result_t expected_q [$];
  int unsigned errors = 0;
  bit hold_off = 1'b0;
  int unsigned idle_cycles = 0;

  function automatic void model_reset();
    thr[REG_GLITCH_MAX] = RstGlitchMax;
    thr[REG_SHORT_MAX]  = RstShortMax;
    thr[REG_LONG_MAX]   = RstLongMax;
    thr[REG_SYNC_MAX]   = RstSyncMax;
    thr[REG_FRAME_GAP]  = RstFrameGap;
    nbits = 0;
    frames = '0;
  endfunction

  function automatic void store_bit(logic b);
    if (nbits >= NBytes * 8) return;
    if (nbits % 8 == 0) store[nbits / 8] = 8'h00;
    store[nbits / 8][nbits % 8] = b;
    nbits++;
  endfunction

  function automatic void flush_frame();
    dec_result_t r;
    int unsigned total, used, nby, left;
    logic [7:0] crc, d;
    if (nbits == 0) return;
    frames++;
    total = nbits;
    r = '0;
    r.dropped = (nbits % 8 == 1);
    if (r.dropped) begin
      used = (nbits + 7) / 8;
      for (int i = 0; i + 1 < used; i++) store[i] = {store[i + 1][0], store[i][7:1]};
      store[used - 1] = store[used - 1] >> 1;
      nbits--;
    end
    nby = nbits / 8;
    left = nbits % 8;
    if (nby >= 2 && left == 0) begin
      crc = 8'h00;
      for (int i = 0; i + 1 < nby; i++) begin
        d = store[i];
        for (int j = 0; j < 8; j++) begin
          crc = ((crc[0] ^ d[0]) == 1'b1) ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
          d = d >> 1;
        end
      end
      r.crc_expected = crc;
      r.crc_status = (crc == store[nby - 1]) ? CRC_MATCH : CRC_MISMATCH;
    end else begin
      r.crc_status = CRC_UNCHECKED;
    end
    for (int i = 0; i < nby; i++) begin
      dec_result_t b;
      b = '0;
      b.kind = KIND_BYTE;
      b.byte_value = store[i];
      b.frame_index = frames;
      expected_q.push_back(b);
    end
    r.kind = KIND_SUMMARY;
    r.total_bits = total[8:0];
    r.leftover = left[2:0];
    r.frame_index = frames;
    expected_q.push_back(r);
    nbits = 0;
  endfunction

  // Works out the results of one accepted transfer and queues them.
  function automatic void decode_edge(logic mode, logic level, logic [31:0] dur);
    int unsigned n0;
    dec_result_t e;
    n0 = expected_q.size();
    if (mode) begin
      if (nbits > 0 && dur > thr[REG_FRAME_GAP]) flush_frame();
    end else if (level) begin
      if (dur < thr[REG_GLITCH_MAX]) begin
      end else if (dur < thr[REG_SHORT_MAX]) begin
        store_bit(1'b1);
      end else if (dur < thr[REG_LONG_MAX]) begin
        store_bit(1'b0);
      end else if (dur < thr[REG_SYNC_MAX]) begin
        flush_frame();
      end else begin
        flush_frame();
        e = '0;
        e.kind = KIND_EVENT;
        e.frame_index = frames;
        e.event_dur = dur;
        expected_q.push_back(e);
      end
    end else if (dur > thr[REG_FRAME_GAP] && nbits > 0) begin
      flush_frame();
    end
    if (expected_q.size() > n0) expected_q[$].last = 1'b1;
  endfunction

  // Result checking.
  always @(posedge clk) begin
    dec_result_t got, w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '0;
      got.kind = kind_t'(m_axis_tuser);
      got.byte_value = m_axis_tdata[7:0];
      got.total_bits = m_axis_tdata[16:8];
      got.dropped = m_axis_tdata[17];
      got.leftover = m_axis_tdata[20:18];
      got.crc_status = crc_status_t'(m_axis_tdata[22:21]);
      got.crc_expected = m_axis_tdata[30:23];
      got.frame_index = m_axis_tdata[62:31];
      got.event_dur = m_axis_tdata[94:63];
      got.last = m_axis_tlast;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result transfer: %p", got);
      end else begin
        w = expected_q.pop_front();
        if (got !== w || m_axis_tdata[95] !== 1'b0) begin
          errors++;
          if (errors <= 10) $display("Mismatch: expected %p, got %p", w, got);
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    int unsigned phase;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off) m_axis_tready <= 1'b0;
      else if (phase % 600 < 150) m_axis_tready <= 1'b1;
      else if (phase % 600 < 400) m_axis_tready <= ($urandom_range(3) != 0);
      else m_axis_tready <= ($urandom_range(2) == 0);
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_edge(logic mode, logic level, logic [31:0] dur);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {7'd0, dur, level};
    do @(posedge clk); while (!s_axis_tready);
    decode_edge(mode, level, dur);
  endtask

  task automatic drop_valid_gap();
    int unsigned g;
    g = ($urandom_range(3) == 0) ? $urandom_range(6, 1) : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr[idx] = v;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // A flush of an empty frame or a bit command may still be in flight.
    repeat (100) @(posedge clk);
  endtask

  // Random pulse in a given class under the current thresholds.
  function automatic logic [31:0] pick_low(int unsigned cls);
    logic [31:0] lo, hi;
    case (cls)
      0: begin lo = 0;                  hi = thr[REG_GLITCH_MAX]; end
      1: begin lo = thr[REG_GLITCH_MAX]; hi = thr[REG_SHORT_MAX]; end
      2: begin lo = thr[REG_SHORT_MAX];  hi = thr[REG_LONG_MAX]; end
      3: begin lo = thr[REG_LONG_MAX];   hi = thr[REG_SYNC_MAX]; end
      default: return $urandom();
    endcase
    if (hi <= lo) return $urandom_range(70000);
    return $urandom_range(hi - 1, lo);
  endfunction

  task automatic random_frame(int unsigned nb);
    for (int i = 0; i < nb; i++) begin
      send_edge(1'b0, 1'b0, $urandom_range(800, 100));
      send_edge(1'b0, 1'b1, pick_low($urandom_range(2, 1)));
      if ($urandom_range(15) == 0) send_edge(1'b0, 1'b1, pick_low(0));
      drop_valid_gap();
    end
    case ($urandom_range(3))
      0: send_edge(1'b0, 1'b1, pick_low(3));
      1: send_edge(1'b1, 1'($urandom_range(1)), $urandom());
      2: send_edge(1'b0, 1'b0, $urandom_range(70000, 1000));
      default: send_edge(1'b0, 1'b1, pick_low(4));
    endcase
  endtask

  // A frame whose last byte is its own CRC, sent as explicit bits under the
  // reset thresholds and closed by a sync pulse.
  task automatic crc_frame(int unsigned nby, bit framing);
    logic [7:0] crc, d, v;
    crc = 8'h00;
    if (framing) send_edge(1'b0, 1'b1, 32'd200);
    for (int i = 0; i < nby; i++) begin
      v = (i == nby - 1) ? crc : 8'($urandom());
      d = v;
      for (int j = 0; j < 8; j++) begin
        crc = ((crc[0] ^ d[0]) == 1'b1) ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
        d = d >> 1;
      end
      for (int j = 0; j < 8; j++) send_edge(1'b0, 1'b1, v[j] ? 32'd200 : 32'd500);
    end
    send_edge(1'b0, 1'b1, 32'd1200);
  endtask

  stim_row_t dir_rows [$];

  function automatic void add_row(logic m, logic l, logic [31:0] d, logic he = 1'b0,
                                  kind_t k = KIND_BYTE);
    stim_row_t r;
    r.mode = m; r.level = l; r.dur = d; r.has_exp = he; r.exp_kind = k; r.exp_dur = d;
    dir_rows.push_back(r);
  endfunction

  initial begin
    int unsigned sent, nb;
    model_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: extremes of the duration, every pulse class, an empty
    // frame end, an idle check, and a framed nine-bit frame.
    add_row(1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1, KIND_EVENT);
    add_row(1'b0, 1'b1, 32'd0);
    add_row(1'b1, 1'b0, 32'hFFFF_FFFF);
    add_row(1'b0, 1'b0, 32'hFFFF_FFFF);
    for (int i = 0; i < 9; i++) add_row(1'b0, 1'b1, (i % 2) ? 32'd500 : 32'd200);
    add_row(1'b0, 1'b0, 32'd1500);
    add_row(1'b0, 1'b1, 32'd99);
    add_row(1'b1, 1'b1, 32'd1501);
    add_row(1'b0, 1'b1, 32'd300);
    add_row(1'b0, 1'b1, 32'd1000);
    for (int i = 0; i < 3; i++) add_row(1'b0, 1'b1, 32'd899);
    add_row(1'b0, 1'b0, 32'd1501);
    add_row(1'b0, 1'b1, 32'd2000, 1'b1, KIND_EVENT);
    foreach (dir_rows[i]) begin
      send_edge(dir_rows[i].mode, dir_rows[i].level, dir_rows[i].dur);
      if (dir_rows[i].has_exp &&
          (expected_q.size() == 0 || expected_q[$].kind != dir_rows[i].exp_kind ||
           expected_q[$].event_dur != dir_rows[i].exp_dur)) begin
        errors++;
        if (errors <= 10) $display("Directed row %0d: model disagrees with table", i);
      end
    end
    wait_drained();

    // Full store with surplus bits, under reset thresholds.
    for (int i = 0; i < 258; i++) send_edge(1'b0, 1'b1, $urandom_range(899, 100));
    send_edge(1'b0, 1'b1, 32'd1200);
    crc_frame(3, 1'b0);
    crc_frame(2, 1'b1);

    // Long hold-off on the receiver while frames keep arriving.
    hold_off = 1'b1;
    fork
      begin
        repeat (3) random_frame(4);
        s_axis_tvalid <= 1'b0;
      end
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    wait_drained();

    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_GLITCH_MAX, 16'd0);
          write_reg(REG_SHORT_MAX, 16'd10);
          write_reg(REG_LONG_MAX, 16'd20);
          write_reg(REG_SYNC_MAX, 16'd30);
          write_reg(REG_FRAME_GAP, 16'd0);
        end
        1: begin
          write_reg(REG_GLITCH_MAX, 16'hFFFF);
          write_reg(REG_SHORT_MAX, 16'hFFFF);
          write_reg(REG_LONG_MAX, 16'hFFFF);
          write_reg(REG_SYNC_MAX, 16'hFFFF);
          write_reg(REG_FRAME_GAP, 16'hFFFF);
        end
        2: begin
          // Misordered thresholds.
          write_reg(REG_GLITCH_MAX, 16'd500);
          write_reg(REG_SHORT_MAX, 16'd300);
          write_reg(REG_LONG_MAX, 16'd2000);
          write_reg(REG_SYNC_MAX, 16'd1000);
          write_reg(REG_FRAME_GAP, 16'd40000);
        end
        default: begin
          write_reg(REG_GLITCH_MAX, RstGlitchMax);
          write_reg(REG_SHORT_MAX, RstShortMax);
          write_reg(REG_LONG_MAX, RstLongMax);
          write_reg(REG_SYNC_MAX, RstSyncMax);
          write_reg(REG_FRAME_GAP, RstFrameGap);
        end
      endcase
      while (sent < (ph + 1) * RandItems / 4) begin
        if ($urandom_range(4) == 0) begin
          send_edge(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
          sent++;
        end else begin
          nb = ($urandom_range(9) == 0) ? $urandom_range(12, 8) : $urandom_range(5);
          random_frame(nb);
          sent += 2 * nb + 1;
        end
        drop_valid_gap();
      end
      wait_drained();
    end

    if (errors == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== pulse_width_frame_decoder_core.f =====
rtl/core/pwfd_pkg.sv
rtl/core/pwfd_front.sv
rtl/core/pwfd_queue.sv
rtl/core/pwfd_back.sv
rtl/core/pulse_width_frame_decoder_core.sv
dv/pulse_width_frame_decoder_core_tb.sv
